### rtl/dusk_pkg.sv
// Shared constants, types and helper functions for the dusk scene pixel generator.
// Holds hash multipliers, palette, ridge height table and the residue helpers.
// No dependencies.
package dusk_pkg;

  localparam logic [31:0] HASH_MUL_A = 32'd374761393;
  localparam logic [31:0] HASH_MUL_B = 32'd668265263;
  localparam logic [31:0] HASH_MUL_C = 32'd1274126177;

  localparam logic [31:0] STAR_COLOR  = 32'hFFE8ECFF;
  localparam logic [31:0] RIDGE_COLOR = 32'hFF191230;
  localparam logic [31:0] EMPTY_COLOR = 32'h0000_0000;

  localparam logic [31:0] BAND_COLOR [8] = '{
    32'hFF0B1026, 32'hFF141A3A, 32'hFF232558, 32'hFF3A2E6E,
    32'hFF5C3B7E, 32'hFF8A4A86, 32'hFFC75B79, 32'hFFF07A5A
  };

  localparam logic [2:0] LAST_BAND = 3'd7;

  // Residue mod 41: 2^10 = -1 (mod 41), so 10-bit digits alternate in sign.
  localparam logic [11:0] FOLD1_BIAS = 12'd1066;  // 26 * 41, keeps the digit sum positive
  localparam logic [10:0] FOLD2_BIAS = 11'd41;
  // 41 * 1049 = 1 (mod 2048); a multiple of 41 maps to 0..49 under that product
  localparam logic [10:0] INV41      = 11'd1049;
  localparam logic [10:0] MUL41_MAX  = 11'd49;

  typedef struct packed {
    logic       in_body;
    logic       ridge;
    logic       star_ok;
    logic [2:0] pick;
  } sky_meta_t;

  function automatic logic [31:0] mix_hash(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] h;
    h = a * HASH_MUL_A + b * HASH_MUL_B;
    h = (h ^ (h >> 13)) * HASH_MUL_C;
    return h ^ (h >> 16);
  endfunction

  // Ridge height per 16-column group: 10 + hash(group, 7) mod 14
  function automatic logic [31:0][4:0] ridge_table();
    logic [31:0][4:0] tab;
    logic [31:0]      h;
    for (int i = 0; i < 32; i++) begin
      h      = mix_hash(32'(i), 32'd7);
      tab[i] = 5'(32'd10 + h % 32'd14);
    end
    return tab;
  endfunction

  localparam logic [31:0][4:0] RIDGE_H = ridge_table();

  // Parity of (band * bh + bh / 2) / 8 for each band
  function automatic logic [7:0] cell_parity(input int unsigned bh);
    logic [7:0]  par;
    int unsigned v;
    for (int unsigned b = 0; b < 8; b++) begin
      v      = (b * bh + (bh >> 1)) >> 3;
      par[b] = v[0];
    end
    return par;
  endfunction

  function automatic logic is_mul41(input logic [10:0] t);
    logic [10:0] p;
    p = 11'(t * INV41);
    return p <= MUL41_MAX;
  endfunction

endpackage

### rtl/dusk_scene_pixel_generator.sv
// Dusk scene pixel generator: one ARGB8888 color per pixel coordinate, transparent outside the body area.
// Throughput one beat per cycle while the output is not stalled (stall_i low).
// Stages: hash premix, hash multiply with sky decode, mod-41 fold, color select.
// Reset clears the stage valid bits only; no clearing pass, ready right after reset.
// Depends on dusk_pkg, dusk_sky and dusk_mod41.
module dusk_scene_pixel_generator
  import dusk_pkg::*;
#(
  parameter int unsigned SCREEN_W   = 480,
  parameter int unsigned SCREEN_H   = 272,
  parameter int unsigned LABEL_ROWS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [8:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] argb_color_o
);

  logic        v1_q, v2_q, v3_q, v4_q;
  logic        rdy1, rdy2, rdy3, rdy4;

  logic [8:0]  x1_q;
  logic [7:0]  y1_q;
  logic [31:0] h1_d, h1_q;
  logic [31:0] m2_d, m2_q;
  sky_meta_t   meta2_d, meta2_q, meta3_q;
  logic [10:0] t3_d, t3_q;
  logic [31:0] color4_d, color4_q;

  // Each stage loads when empty or when the stage after it moves.
  assign rdy4    = !v4_q || !stall_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign stall_o = !rdy1;

  assign h1_d = ({23'd0, pixel_x_i} * HASH_MUL_A) + ({24'd0, pixel_y_i} * HASH_MUL_B);
  assign m2_d = (h1_q ^ (h1_q >> 13)) * HASH_MUL_C;

  dusk_sky #(
    .SCREEN_W  (SCREEN_W),
    .SCREEN_H  (SCREEN_H),
    .LABEL_ROWS(LABEL_ROWS)
  ) u_sky (
    .pixel_x_i(x1_q),
    .pixel_y_i(y1_q),
    .meta_o   (meta2_d)
  );

  dusk_mod41 u_mod41 (
    .mix_i  (m2_q),
    .resid_o(t3_d)
  );

  always_comb begin
    if (!meta3_q.in_body) begin
      color4_d = EMPTY_COLOR;
    end else if (meta3_q.ridge) begin
      color4_d = RIDGE_COLOR;
    end else if (meta3_q.star_ok && is_mul41(t3_q)) begin
      color4_d = STAR_COLOR;
    end else begin
      color4_d = BAND_COLOR[meta3_q.pick];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      x1_q <= pixel_x_i;
      y1_q <= pixel_y_i;
      h1_q <= h1_d;
    end
    if (rdy2) begin
      m2_q    <= m2_d;
      meta2_q <= meta2_d;
    end
    if (rdy3) begin
      t3_q    <= t3_d;
      meta3_q <= meta2_q;
    end
    if (rdy4) begin
      color4_q <= color4_d;
    end
  end

  assign valid_o      = v4_q;
  assign argb_color_o = color4_q;

endmodule

### rtl/dusk_sky.sv
// Sky decode: band, dither pick, star grid eligibility and ridge cover for one pixel.
// Depends on dusk_pkg (sky_meta_t, RIDGE_H, cell_parity).
module dusk_sky
  import dusk_pkg::*;
#(
  parameter int unsigned SCREEN_W   = 480,
  parameter int unsigned SCREEN_H   = 272,
  parameter int unsigned LABEL_ROWS = 24
) (
  input  logic [8:0] pixel_x_i,
  input  logic [7:0] pixel_y_i,
  output sky_meta_t  meta_o
);

  localparam int unsigned BH      = (SCREEN_H > LABEL_ROWS) ? SCREEN_H - LABEL_ROWS : 0;
  localparam logic [12:0] BH_W    = 13'(BH);
  localparam logic [12:0] BH_HALF = 13'(BH / 2);
  localparam logic [12:0] W_LIM   = 13'(SCREEN_W);
  localparam logic [7:0]  CELL_PAR = cell_parity(BH);

  logic [12:0] x_w;
  logic [12:0] y_w;
  logic [16:0] y16;
  logic [3:0]  q16;
  logic [2:0]  band;
  logic [2:0]  next_band;
  logic        dither_odd;
  logic [4:0]  rh;

  assign x_w = {4'd0, pixel_x_i};
  assign y_w = {5'd0, pixel_y_i};
  assign y16 = {5'd0, pixel_y_i, 4'd0};

  // floor(16 * y / BH) from fifteen monotonic threshold compares
  always_comb begin
    q16 = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (y16 >= 17'(k * BH)) q16 = 4'(k);
    end
  end

  assign band       = q16[3:1];
  assign next_band  = (band == LAST_BAND) ? LAST_BAND : band + 3'd1;
  assign dither_odd = pixel_y_i[3] ^ CELL_PAR[band];
  assign rh         = RIDGE_H[pixel_x_i[8:4]];

  always_comb begin
    meta_o.in_body = (BH_W != 13'd0) && (x_w < W_LIM) && (y_w < BH_W);
    meta_o.pick    = (q16[0] && dither_odd) ? next_band : band;
    meta_o.star_ok = (y_w >= 13'd8) && (y_w < BH_HALF) && (pixel_y_i[2:0] == 3'd0) &&
                     (x_w >= 13'd4) && (x_w + 13'd4 < W_LIM) && (pixel_x_i[2:0] == 3'd4);
    meta_o.ridge   = ({8'd0, rh} <= BH_W) && (y_w + {8'd0, rh} >= BH_W);
  end

endmodule

### rtl/dusk_mod41.sv
// Finishes the 32-bit star hash and folds it to a small value with the same residue mod 41.
// Depends on dusk_pkg (fold biases).
module dusk_mod41
  import dusk_pkg::*;
(
  input  logic [31:0] mix_i,
  output logic [10:0] resid_o
);

  logic [31:0] h;
  logic [11:0] s;

  assign h = mix_i ^ (mix_i >> 16);

  // digits at 2^0 and 2^20 add, digits at 2^10 and 2^30 subtract
  assign s = {2'd0, h[9:0]} + {2'd0, h[29:20]} + FOLD1_BIAS
           - {2'd0, h[19:10]} - {10'd0, h[31:30]};

  assign resid_o = {1'b0, s[9:0]} + FOLD2_BIAS - {9'd0, s[11:10]};

endmodule

### tb/dusk_scene_pixel_generator_test.sv
// Self-checking bench for dusk_scene_pixel_generator: directed probe rows, then random pixels.
// Every output beat is checked against an expected color, listed or from a local color predictor; needs only the RTL
// (dusk_pkg, dusk_scene_pixel_generator and its submodules).
module dusk_scene_pixel_generator_test;

  localparam int unsigned PIX_COLS    = 480;
  localparam int unsigned PIX_ROWS    = 272;
  localparam int unsigned LABEL_LINES = 24;
  localparam int unsigned BODY_H      = (PIX_ROWS > LABEL_LINES) ? PIX_ROWS - LABEL_LINES : 0;

  localparam logic [31:0] MIX_X     = 32'd374761393;
  localparam logic [31:0] MIX_Y     = 32'd668265263;
  localparam logic [31:0] MIX_FINAL = 32'd1274126177;

  localparam logic [31:0] STAR_ARGB  = 32'hFFE8ECFF;
  localparam logic [31:0] RIDGE_ARGB = 32'hFF191230;
  localparam logic [31:0] CLEAR_ARGB = 32'h0000_0000;
  localparam logic [31:0] BAND0_ARGB = 32'hFF0B1026;
  localparam int unsigned TOP_BAND   = 7;

  localparam int unsigned PIPE_DEPTH   = 4;
  localparam int unsigned PHASE_ITEMS  = 260;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PROBE_COUNT  = 22;

  typedef struct packed {
    logic [8:0]  x;
    logic [7:0]  y;
    logic [31:0] color;
    logic        known;
  } probe_t;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [8:0]  pixel_x_i;
  logic [7:0]  pixel_y_i;
  logic        valid_o;
  logic        stall_i;
  logic [31:0] argb_color_o;

  logic [31:0] pending_colors [$];
  probe_t      probes [PROBE_COUNT];
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  logic        hold_req;
  int unsigned mismatches;
  int unsigned cycle_count;

  dusk_scene_pixel_generator #(
    .SCREEN_W  (PIX_COLS),
    .SCREEN_H  (PIX_ROWS),
    .LABEL_ROWS(LABEL_LINES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .argb_color_o(argb_color_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] pixel_hash(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] h;
    h = a * MIX_X + b * MIX_Y;
    h = h ^ (h >> 13);
    h = h * MIX_FINAL;
    return h ^ (h >> 16);
  endfunction

  function automatic logic [31:0] sky_shade(input int unsigned band);
    case (band)
      0:       return BAND0_ARGB;
      1:       return 32'hFF141A3A;
      2:       return 32'hFF232558;
      3:       return 32'hFF3A2E6E;
      4:       return 32'hFF5C3B7E;
      5:       return 32'hFF8A4A86;
      6:       return 32'hFFC75B79;
      default: return 32'hFFF07A5A;
    endcase
  endfunction

  function automatic logic [31:0] dusk_color(input logic [8:0] px, input logic [7:0] py);
    int unsigned x, y, band, dither_odd, next, half, rh;
    logic [31:0] shade;
    x = px;
    y = py;
    if (BODY_H == 0 || x >= PIX_COLS || y >= BODY_H) return CLEAR_ARGB;
    band = (y * 8) / BODY_H;
    if (band > TOP_BAND) band = TOP_BAND;
    // dither the lower half of each band toward the next one in 8-row cells
    dither_odd = ((y >> 3) + ((band * BODY_H + BODY_H / 2) / 8)) & 1;
    next = (band < TOP_BAND) ? band + 1 : TOP_BAND;
    half = ((y * 16) / BODY_H) & 1;
    shade = sky_shade((half != 0 && dither_odd != 0) ? next : band);
    if (y >= 8 && y < BODY_H / 2 && (y & 7) == 0 &&
        x >= 4 && x + 4 < PIX_COLS && (x & 7) == 4) begin
      if (pixel_hash(x, y) % 41 == 0) shade = STAR_ARGB;
    end
    rh = 10 + pixel_hash(x >> 4, 7) % 14;
    if (rh <= BODY_H && y >= BODY_H - rh) shade = RIDGE_ARGB;
    return shade;
  endfunction

  // Weight toward star grid points and ridge rows; keep some beats outside the body.
  task automatic random_pixel(output logic [8:0] x, output logic [7:0] y);
    int unsigned mode;
    mode = $urandom_range(99, 0);
    if (mode < 55) begin
      x = 9'($urandom_range(PIX_COLS - 1, 0));
      y = 8'($urandom_range(BODY_H - 1, 0));
    end else if (mode < 75) begin
      x = 9'(8 * $urandom_range(59, 0) + 4);
      y = 8'(8 * $urandom_range(15, 1));
    end else if (mode < 88) begin
      x = 9'($urandom_range(PIX_COLS - 1, 0));
      y = 8'($urandom_range(BODY_H - 1, BODY_H - 32));
    end else begin
      x = 9'($urandom_range(511, 0));
      y = 8'($urandom_range(255, 0));
    end
  endtask

  // Offer one beat; valid stays high after acceptance until the next gap lowers it.
  task automatic offer_pixel(input logic [8:0] x, input logic [7:0] y, input logic [31:0] color);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i   <= 1'b1;
    pixel_x_i <= x;
    pixel_y_i <= y;
    do @(posedge clk_i); while (stall_o !== 1'b0);
    pending_colors.push_back(color);
  endtask

  task automatic drain_colors();
    valid_i <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [8:0] rx;
    logic [7:0] ry;
    rst_ni       = 1'b0;
    valid_i      = 1'b0;
    pixel_x_i    = '0;
    pixel_y_i    = '0;
    hold_req     = 1'b0;
    src_idle_pct = 31;
    sink_stall_pct = 82;
    probes = '{
      '{9'd0,   8'd0,   BAND0_ARGB, 1'b1},
      '{9'd479, 8'd0,   BAND0_ARGB, 1'b1},
      '{9'd480, 8'd0,   CLEAR_ARGB, 1'b1},
      '{9'd511, 8'd255, CLEAR_ARGB, 1'b1},
      '{9'd0,   8'd248, CLEAR_ARGB, 1'b1},
      '{9'd479, 8'd248, CLEAR_ARGB, 1'b1},
      '{9'd0,   8'd247, RIDGE_ARGB, 1'b1},
      '{9'd479, 8'd247, RIDGE_ARGB, 1'b1},
      '{9'd256, 8'd128, 32'h0,      1'b0},
      '{9'd255, 8'd127, 32'h0,      1'b0},
      '{9'd4,   8'd8,   32'h0,      1'b0},
      '{9'd468, 8'd120, 32'h0,      1'b0},
      '{9'd476, 8'd120, 32'h0,      1'b0},
      '{9'd12,  8'd124, 32'h0,      1'b0},
      '{9'd100, 8'd216, 32'h0,      1'b0},
      '{9'd100, 8'd217, 32'h0,      1'b0},
      '{9'd300, 8'd232, 32'h0,      1'b0},
      '{9'd300, 8'd240, 32'h0,      1'b0},
      '{9'd64,  8'd224, 32'h0,      1'b0},
      '{9'd64,  8'd225, 32'h0,      1'b0},
      '{9'd0,   8'd8,   32'h0,      1'b0},
      '{9'd37,  8'd15,  32'h0,      1'b0}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PROBE_COUNT; i++) begin
      offer_pixel(probes[i].x, probes[i].y,
                  probes[i].known ? probes[i].color : dusk_color(probes[i].x, probes[i].y));
    end

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct   = (phase == 0) ? 31 : (phase == 1) ? 82 : 0;
      sink_stall_pct = (phase == 0) ? 82 : (phase == 1) ? 31 : 0;
      // back-pressure the pipeline while the sender keeps offering
      if (phase == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_pixel(rx, ry);
        offer_pixel(rx, ry, dusk_color(rx, ry));
        if (phase == 2 && n == PHASE_ITEMS / 2) begin
          drain_colors();
          @(posedge clk_i);
        end
      end
    end

    drain_colors();
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned hold_left;
    logic        hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    stall_i    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        stall_i <= 1'b1;
      end else begin
        stall_i <= ($urandom_range(99, 0) < sink_stall_pct);
      end
    end
  end

  initial mismatches = 0;

  always @(posedge clk_i) begin : check_colors
    logic [31:0] want;
    if (rst_ni && valid_o === 1'b1 && stall_i === 1'b0) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, argb_color_o);
        mismatches++;
      end else begin
        want = pending_colors.pop_front();
        if (argb_color_o !== want) begin
          $display("%0t: argb_color mismatch, expected %h, actual %h", $time, want, argb_color_o);
          mismatches++;
        end
      end
    end
  end

  initial cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d colors outstanding", $time, pending_colors.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
